@@ src/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types, constants and helpers of the radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned RADIX_BITS = 6;
  localparam int unsigned DIGIT_BITS = 6;
  localparam int unsigned CHAR_BITS  = 7;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS = 4;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NINE = 6'd9;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_BITS-1:0]  CHAR_A     = 7'd65;
  localparam logic [CHAR_BITS-1:0]  ALPHA_BASE = 7'd10;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NEXT = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] ext;
    ext = {1'b0, d};
    if (d <= DIGIT_NINE) begin
      return CHAR_ZERO + ext;
    end
    return CHAR_A + ext - ALPHA_BASE;
  endfunction

  function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

@@ src/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// iterative restoring divider, a few quotient bits per cycle, narrow divisor
// ----------------------------------------------------------------------------
module rdc_divider #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_WIDTH-1:0]            dividend_i,
  input  logic [rdc_pkg::RADIX_BITS-1:0]    divisor_i,
  output logic                              done_o,
  output logic [VALUE_WIDTH-1:0]            quotient_o,
  output logic [rdc_pkg::DIGIT_BITS-1:0]    remainder_o
);

  localparam int unsigned STEPS  = rdc_pkg::DIV_STEPS;
  localparam int unsigned CYCLES = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int unsigned PAD_W  = CYCLES * STEPS;
  localparam int unsigned CW     = $clog2(CYCLES + 1);
  localparam int unsigned RB     = rdc_pkg::DIGIT_BITS;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [PAD_W-1:0]            work_q, work_d;
  logic [RB-1:0]               rem_q, rem_d;
  logic [rdc_pkg::RADIX_BITS-1:0] div_q, div_d;

  logic [PAD_W-1:0]            work_s;
  logic [RB-1:0]               rem_s;
  logic [RB:0]                 trial;

  always_comb begin
    work_s = work_q;
    rem_s  = rem_q;
    trial  = '0;
    for (int unsigned i = 0; i < STEPS; i++) begin
      trial = {rem_s, work_s[PAD_W-1]};
      if (trial >= {1'b0, div_q}) begin
        trial  = trial - {1'b0, div_q};
        work_s = {work_s[PAD_W-2:0], 1'b1};
      end else begin
        work_s = {work_s[PAD_W-2:0], 1'b0};
      end
      rem_s = trial[RB-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(CYCLES);
      work_d = PAD_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      work_d = work_s;
      rem_d  = rem_s;
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

@@ src/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// converts one unsigned value into ascii digits in a configured base
// ----------------------------------------------------------------------------
// Each accepted value is split into digits by repeated division by the base
// (2 to 36; lower register values act as 2, higher as 36). The divider
// resolves four quotient bits per cycle; digits go into a digit memory least
// significant first. Emission then reads that memory in reverse at one digit
// per cycle while the output does not stall, most significant digit first,
// with last set on the final digit; a zero value gives a single '0'. The next
// value is taken once the last digit has left the memory read stage, while
// that digit may still wait in the output register.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rdc_pkg::RADIX_BITS-1:0]      cfg_radix_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rdc_pkg::VALUE_BITS-1:0]      value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rdc_pkg::CHAR_BITS-1:0]       digit_char_o,
  output logic                                last_o
);

  localparam int unsigned IN_W = rdc_pkg::VALUE_BITS;
  localparam int unsigned AW   = $clog2(MAX_DIGITS);
  localparam int unsigned CNTW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned DB   = rdc_pkg::DIGIT_BITS;

  rdc_pkg::state_e state_q, state_d;

  logic [rdc_pkg::RADIX_BITS-1:0] radix_q, radix_d;
  logic [VALUE_WIDTH-1:0]         quot_q, quot_d;
  logic [CNTW-1:0]                cnt_q, cnt_d;
  logic [CNTW-1:0]                left_q, left_d;
  logic [AW-1:0]                  rd_idx_q, rd_idx_d;
  logic                           a_valid_q, a_valid_d;
  logic                           a_last_q, a_last_d;
  logic                           out_valid_q, out_valid_d;
  logic [rdc_pkg::CHAR_BITS-1:0]  out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0]         value_ext;
  logic                           in_accept;
  logic                           out_load;
  logic                           a_move;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [DB-1:0]                  mem_wdata;
  logic                           mem_re;
  logic [DB-1:0]                  rd_data_q;
  logic [DB-1:0]                  mem_q [MAX_DIGITS];

  logic                           div_start;
  logic                           div_done;
  logic [VALUE_WIDTH-1:0]         div_quot;
  logic [DB-1:0]                  div_rem;

  if (VALUE_WIDTH > IN_W) begin : g_ext
    assign value_ext = {{(VALUE_WIDTH - IN_W){1'b0}}, value_i};
  end else begin : g_trunc
    assign value_ext = value_i[VALUE_WIDTH-1:0];
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rdc_pkg::S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  rdc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (quot_q),
    .divisor_i   (rdc_pkg::clamp_radix(radix_q)),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign out_load = a_valid_q && (!out_valid_q || !out_stall_i);
  assign a_move   = out_load;

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    rd_idx_d    = rd_idx_q;
    a_valid_d   = a_valid_q;
    a_last_d    = a_last_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = div_rem;
    mem_re      = 1'b0;
    div_start   = 1'b0;

    if (cfg_valid_i) begin
      radix_d = cfg_radix_i;
    end

    // output register
    if (out_load) begin
      out_valid_d = 1'b1;
      out_char_d  = rdc_pkg::digit_to_ascii(rd_data_q);
      out_last_d  = a_last_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // memory read stage
    if (a_move) begin
      a_valid_d = 1'b0;
    end
    if ((state_q == rdc_pkg::S_EMIT) && (left_q != '0) && (!a_valid_q || a_move)) begin
      mem_re    = 1'b1;
      a_valid_d = 1'b1;
      a_last_d  = (left_q == CNTW'(1));
      left_d    = left_q - CNTW'(1);
      rd_idx_d  = rd_idx_q - AW'(1);
    end

    unique case (state_q)
      rdc_pkg::S_IDLE: begin
        if (in_accept) begin
          quot_d  = value_ext;
          cnt_d   = '0;
          state_d = rdc_pkg::S_NEXT;
        end
      end
      rdc_pkg::S_NEXT: begin
        priority if ((quot_q == '0) && (cnt_q == '0)) begin
          // zero value: single digit zero
          mem_we    = 1'b1;
          mem_wdata = '0;
          cnt_d     = CNTW'(1);
        end else if ((quot_q == '0) || (cnt_q == CNTW'(MAX_DIGITS))) begin
          left_d   = cnt_q;
          rd_idx_d = AW'(cnt_q - CNTW'(1));
          state_d  = rdc_pkg::S_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = rdc_pkg::S_DIV;
        end
      end
      rdc_pkg::S_DIV: begin
        if (div_done) begin
          mem_we  = 1'b1;
          cnt_d   = cnt_q + CNTW'(1);
          quot_d  = div_quot;
          state_d = rdc_pkg::S_NEXT;
        end
      end
      rdc_pkg::S_EMIT: begin
        if ((left_q == '0) && !a_valid_q) begin
          state_d = rdc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rdc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdc_pkg::S_IDLE;
      radix_q     <= rdc_pkg::RADIX_RESET;
      cnt_q       <= '0;
      left_q      <= '0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    rd_idx_q   <= rd_idx_d;
    a_last_q   <= a_last_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // digit memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;

endmodule

@@ dv/tb_radix_digit_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter
// self-checking bench for the radix digit converter
// ----------------------------------------------------------------------------
// Values go in through the stall handshake with random gaps, and the output
// side stalls at random. Each accepted item is turned into its expected digit
// characters under the current base. A checker pops one character per
// accepted output and compares it. Items first run at the reset base, and
// the base register is written only while the block is drained: at the ends
// of its range, at 16, at settings outside that range, and at random settings.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 19;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [6:0] ASCII_ZERO   = 7'd48;
  localparam logic [6:0] ASCII_LETTER = 7'd55;  // 'A' minus ten
  localparam logic [5:0] BASE_MIN     = 6'd2;
  localparam logic [5:0] BASE_MAX     = 6'd36;

  typedef struct packed {
    logic [rdc_pkg::CHAR_BITS-1:0] ch;
    logic                          last;
  } digit_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [rdc_pkg::RADIX_BITS-1:0]  cfg_radix_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [rdc_pkg::VALUE_BITS-1:0]  value_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [rdc_pkg::CHAR_BITS-1:0]   digit_char_o;
  logic                            last_o;

  digit_t                          expected_digits[$];
  logic [rdc_pkg::RADIX_BITS-1:0]  radix_setting;
  int unsigned                     mismatch_cnt;
  int unsigned                     idle_cycles;

  radix_digit_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_radix_i (cfg_radix_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [5:0] effective_base(input logic [5:0] r);
    if (r < BASE_MIN) begin
      return BASE_MIN;
    end
    if (r > BASE_MAX) begin
      return BASE_MAX;
    end
    return r;
  endfunction

  // mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 3);
    end
    if (roll < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void predict_digits(input logic [31:0] v);
    logic [5:0]  base;
    logic [31:0] q;
    logic [5:0]  digs[$];
    logic [5:0]  d;
    digit_t      item;
    base = effective_base(radix_setting);
    q = v;
    do begin
      digs.push_back(6'(q % base));
      q = q / base;
    end while (q != 0);
    for (int i = digs.size() - 1; i >= 0; i--) begin
      d = digs[i];
      item.ch = (d < 6'd10) ? ASCII_ZERO + 7'(d) : ASCII_LETTER + 7'(d);
      item.last = (i == 0);
      expected_digits.push_back(item);
    end
  endfunction

  function automatic logic [31:0] random_value(input logic [5:0] base);
    int unsigned roll;
    int unsigned k;
    logic [63:0] p;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return $urandom;
    end
    if (roll < 70) begin
      return $urandom >> $urandom_range(0, 31);
    end
    if (roll < 85) begin
      return $urandom_range(0, int'(base) * int'(base));
    end
    // powers of the base and one below them
    p = 64'd1;
    k = $urandom_range(1, 32);
    while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
      p = p * base;
      k--;
    end
    return $urandom_range(0, 1) ? p[31:0] : p[31:0] - 32'd1;
  endfunction

  task automatic send_value(input logic [31:0] v);
    int unsigned gap;
    gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digits(v);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [5:0] r);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_radix_i <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    radix_setting = r;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_base();
    send_value(32'd0);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd99);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1_000_000_000);
  endtask

  task automatic test_binary_and_hex();
    write_radix(6'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1);
    write_radix(6'd16);
    send_value(32'hDEAD_BEEF);
    send_value(32'h0000_000F);
  endtask

  task automatic test_base36();
    write_radix(6'd36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
  endtask

  // settings outside 2..36 act as the nearest end
  task automatic test_radix_clamp();
    write_radix(6'd0);
    send_value(32'd5);
    write_radix(6'd1);
    send_value(32'd7);
    write_radix(6'd37);
    send_value(32'd35);
    write_radix(6'd63);
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_random();
    logic [5:0] r;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          r = 6'd2;
        end
        1: begin
          r = 6'd36;
        end
        2: begin
          r = 6'd63;
        end
        3: begin
          r = 6'd0;
        end
        default: begin
          r = 6'($urandom_range(0, 63));
        end
      endcase
      write_radix(r);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(random_value(effective_base(r)));
      end
    end
  endtask

  always @(posedge clk_i) begin : check_digits
    digit_t exp_d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_digits.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("unexpected item: char %0d last %0b", digit_char_o, last_o);
        end
      end else begin
        exp_d = expected_digits.pop_front();
        if (digit_char_o !== exp_d.ch || last_o !== exp_d.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
                     exp_d.ch, exp_d.last, digit_char_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stall_gen
    int unsigned run_len;
    int unsigned hold_len;
    out_stall_i <= 1'b0;
    forever begin
      run_len = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0) begin
        run_len += 80;
      end
      repeat (run_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      hold_len = pick_gap();
      repeat (hold_len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_radix_i   <= '0;
    in_valid_i    <= 1'b0;
    value_i       <= '0;
    mismatch_cnt  = 0;
    radix_setting = rdc_pkg::RADIX_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_base();
    test_binary_and_hex();
    test_base36();
    test_radix_clamp();
    test_random();

    drain();
    repeat (60) @(posedge clk_i);
    mismatch_cnt += expected_digits.size();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
